// File: design/asidba_pkg.sv
`timescale 1ns / 1ps
package asidba_pkg;

   localparam int ID_COUNT    = 128;
   localparam int MAX_REQUEST = 16;
   localparam int WORD_BITS   = 32;

   localparam int NUM_WORDS   = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int TOTAL_BITS  = NUM_WORDS * WORD_BITS;
   localparam int NUM_FIXED   = 4;

   localparam int ID_W        = 7;
   localparam int COUNT_W     = 5;
   localparam int WORD_CNT_W  = $clog2(NUM_WORDS + 1);
   localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int MAP_IDX_W   = $clog2(TOTAL_BITS);
   localparam int GOT_W       = $clog2(MAX_REQUEST + 1);
   localparam int LOG_IDX_W   = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;

   localparam logic MODE_RESERVE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_NO_ID = 1'b1;

   localparam logic [ID_W-1:0] FIXED_IDS [NUM_FIXED] = '{7'd0, 7'd1, 7'd2, 7'd3};

   typedef logic [TOTAL_BITS-1:0] map_type;

   function automatic map_type reset_map();
      map_type m;
      m = '0;
      for (int i = 0; i < NUM_FIXED; i++) begin
         if (int'(FIXED_IDS[i]) < ID_COUNT) m[MAP_IDX_W'(FIXED_IDS[i])] = 1'b1;
      end
      return m;
   endfunction

   // bits past the last identifier never count as free
   function automatic map_type id_mask();
      map_type m;
      m = '0;
      for (int i = 0; i < TOTAL_BITS; i++) begin
         if (i < ID_COUNT) m[i] = 1'b1;
      end
      return m;
   endfunction

   localparam map_type RESET_MAP  = reset_map();
   localparam map_type VALID_MASK = id_mask();

   typedef struct packed {
      logic               mode;
      logic [COUNT_W-1:0] count;
      logic [ID_W-1:0]    asid;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] granted_id;
      logic            status;
      logic            last;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_ROLLBACK = 6'b000100,
      S_EMIT     = 6'b001000,
      S_FAIL     = 6'b010000,
      S_ACK      = 6'b100000
   } state_type;

   typedef struct packed {
      logic start;
      logic release_id;
      logic claim;
      logic next_word;
      logic zero_k;
      logic unclaim;
      logic k_inc;
      logic push_grant;
      logic push_fail;
      logic push_ack;
   } cmd_type;

   typedef struct packed {
      logic req_release;
      logic req_bad;
      logic got_done;
      logic word_end;
      logic has_free;
      logic k_done;
      logic k_last;
      logic out_free;
   } stat_type;

endpackage

// File: design/asidba_dp.sv
`timescale 1ns / 1ps
module asidba_dp (
   input  logic                clock,
   input  logic                reset,
   input  asidba_pkg::req_type req_data,
   input  asidba_pkg::cmd_type cmd,
   output asidba_pkg::stat_type stat,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output asidba_pkg::rsp_type rsp_data
);

   asidba_pkg::map_type map_ff, map_in;
   logic [asidba_pkg::WORD_CNT_W-1:0] word_ff, word_in;
   logic [asidba_pkg::GOT_W-1:0]      got_ff, got_in;
   logic [asidba_pkg::GOT_W-1:0]      k_ff, k_in;
   logic [asidba_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [asidba_pkg::ID_W-1:0]       asid_ff, asid_in;
   logic [asidba_pkg::ID_W-1:0]       log_ff [asidba_pkg::MAX_REQUEST];
   logic                              rsp_valid_ff, rsp_valid_in;
   asidba_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   asidba_pkg::map_type                free_vec;
   logic [asidba_pkg::WORD_IDX_W-1:0]  word_lo;
   logic [asidba_pkg::WORD_BITS-1:0]   word_free;
   logic [asidba_pkg::BIT_IDX_W-1:0]   enc;
   logic [asidba_pkg::MAP_IDX_W-1:0]   claim_idx;
   logic [asidba_pkg::ID_W-1:0]        claim_id;
   logic [asidba_pkg::ID_W-1:0]        log_rd;
   logic                               word_end;
   logic                               out_free;

   assign free_vec = ~map_ff & asidba_pkg::VALID_MASK;
   assign word_lo  = asidba_pkg::WORD_IDX_W'(word_ff);
   assign word_end = int'(word_ff) >= asidba_pkg::NUM_WORDS;

   always_comb begin
      word_free = '0;
      if (!word_end) begin
         word_free = free_vec[int'(word_lo) * asidba_pkg::WORD_BITS +: asidba_pkg::WORD_BITS];
      end
   end

   // lowest free bit of the current word
   always_comb begin
      enc = '0;
      for (int b = asidba_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (word_free[b]) enc = asidba_pkg::BIT_IDX_W'(b);
      end
   end

   assign claim_idx = asidba_pkg::MAP_IDX_W'(int'(word_lo) * asidba_pkg::WORD_BITS + int'(enc));
   assign claim_id  = asidba_pkg::ID_W'(claim_idx);
   assign log_rd    = log_ff[asidba_pkg::LOG_IDX_W'(k_ff)];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.req_release = req_data.mode == asidba_pkg::MODE_RELEASE;
      stat.req_bad     = (req_data.count == '0) ||
                         (int'(req_data.count) > asidba_pkg::MAX_REQUEST);
      stat.got_done    = int'(got_ff) == int'(count_ff);
      stat.word_end    = word_end;
      stat.has_free    = |word_free;
      stat.k_done      = k_ff == got_ff;
      stat.k_last      = int'(k_ff) + 1 == int'(count_ff);
      stat.out_free    = out_free;
   end

   always_comb begin
      map_in   = map_ff;
      word_in  = word_ff;
      got_in   = got_ff;
      k_in     = k_ff;
      count_in = count_ff;
      asid_in  = asid_ff;
      if (cmd.release_id) begin
         asid_in = req_data.asid;
         if (int'(req_data.asid) < asidba_pkg::ID_COUNT) begin
            map_in[asidba_pkg::MAP_IDX_W'(req_data.asid)] = 1'b0;
         end
      end
      if (cmd.start) begin
         count_in = req_data.count;
         word_in  = '0;
         got_in   = '0;
      end
      if (cmd.claim) begin
         map_in[claim_idx] = 1'b1;
         got_in = got_ff + 1'b1;
      end
      if (cmd.next_word) word_in = word_ff + 1'b1;
      // undo one claim of a request that could not be met
      if (cmd.unclaim && int'(log_rd) < asidba_pkg::ID_COUNT) begin
         map_in[asidba_pkg::MAP_IDX_W'(log_rd)] = 1'b0;
      end
      if (cmd.zero_k) k_in = '0;
      if (cmd.k_inc)  k_in = k_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.push_grant) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.granted_id = log_rd;
         rsp_data_in.status     = asidba_pkg::STATUS_OK;
         rsp_data_in.last       = stat.k_last;
      end else if (cmd.push_fail) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.granted_id = '0;
         rsp_data_in.status     = asidba_pkg::STATUS_NO_ID;
         rsp_data_in.last       = 1'b1;
      end else if (cmd.push_ack) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.granted_id = asid_ff;
         rsp_data_in.status     = asidba_pkg::STATUS_OK;
         rsp_data_in.last       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= asidba_pkg::RESET_MAP;
         word_ff      <= '0;
         got_ff       <= '0;
         k_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         word_ff      <= word_in;
         got_ff       <= got_in;
         k_ff         <= k_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asid_ff     <= asid_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.claim) log_ff[asidba_pkg::LOG_IDX_W'(got_ff)] <= claim_id;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/asidba_ctrl.sv
`timescale 1ns / 1ps
module asidba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  asidba_pkg::stat_type stat,
   output asidba_pkg::cmd_type  cmd
);

   asidba_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         asidba_pkg::S_IDLE: begin
            if (req_valid) begin
               if (stat.req_release) begin
                  cmd.release_id = 1'b1;
                  state_in = asidba_pkg::S_ACK;
               end else if (stat.req_bad) begin
                  state_in = asidba_pkg::S_FAIL;
               end else begin
                  cmd.start = 1'b1;
                  state_in = asidba_pkg::S_SCAN;
               end
            end
         end
         asidba_pkg::S_SCAN: begin
            if (stat.got_done) begin
               cmd.zero_k = 1'b1;
               state_in = asidba_pkg::S_EMIT;
            end else if (stat.word_end) begin
               cmd.zero_k = 1'b1;
               state_in = asidba_pkg::S_ROLLBACK;
            end else if (stat.has_free) begin
               cmd.claim = 1'b1;
            end else begin
               cmd.next_word = 1'b1;
            end
         end
         asidba_pkg::S_ROLLBACK: begin
            if (stat.k_done) begin
               state_in = asidba_pkg::S_FAIL;
            end else begin
               cmd.unclaim = 1'b1;
               cmd.k_inc   = 1'b1;
            end
         end
         asidba_pkg::S_EMIT: begin
            if (stat.out_free) begin
               cmd.push_grant = 1'b1;
               cmd.k_inc      = 1'b1;
               if (stat.k_last) state_in = asidba_pkg::S_IDLE;
            end
         end
         asidba_pkg::S_FAIL: begin
            if (stat.out_free) begin
               cmd.push_fail = 1'b1;
               state_in = asidba_pkg::S_IDLE;
            end
         end
         asidba_pkg::S_ACK: begin
            if (stat.out_free) begin
               cmd.push_ack = 1'b1;
               state_in = asidba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = asidba_pkg::S_IDLE;
         end
      endcase
   end

   assign req_stall = state_ff != asidba_pkg::S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asidba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/asid_bitmap_allocator.sv
`timescale 1ns / 1ps
// Address-space identifier allocator over a bitmap of ID_COUNT bits.
// Request channel (req_valid / req_stall / req_data): mode 0 reserves count
// identifiers, mode 1 releases req_data.asid. One request is in the block at
// a time; req_stall stays high from the cycle after acceptance until its last
// result has been loaded into the output register.
// Result channel (rsp_valid / rsp_stall / rsp_data): a reserve that succeeds
// gives count items in ascending identifier order, the final one with last
// set; a reserve that cannot be met gives one item with status 1 and
// granted_id 0; a release gives one acknowledgement echoing the identifier.
// A release, or a reserve with a count of zero or above MAX_REQUEST, goes
// from S_IDLE straight to S_ACK or S_FAIL, which loads its item once the
// result side is free. A reserve claims one identifier per cycle with a
// find-first-zero encoder and steps to the next word when a word is fully
// taken; it then gives one result per cycle while rsp_stall is low. A
// reserve that cannot be met walks all NUM_WORDS words, then undoes each
// claim before its failure item. Reset clears the bitmap to identifiers
// 0 to 3 taken. While rsp_stall is high the waiting item holds; the states
// that load a result wait until it is taken, while scanning and undoing
// claims go on.
module asid_bitmap_allocator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  asidba_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output asidba_pkg::rsp_type rsp_data
);

   asidba_pkg::cmd_type  cmd;
   asidba_pkg::stat_type stat;

   asidba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   asidba_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_fail_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.last && rsp_data.granted_id == '0)
      else $error("failure item is not a single zero-id final item");

   a_one_request : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   a_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("grant burst broke before its final item");

   a_busy_mid_burst : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request accepted while a grant burst is unfinished");

endmodule

// File: tb/sv/asid_bitmap_allocator_test.sv
`timescale 1ns / 1ps
module asid_bitmap_allocator_test;

   localparam int RANDOM_ITEMS = 250;
   localparam int CALM_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic                           typed;
      logic                           fail;
      logic [asidba_pkg::ID_W-1:0]    first;
      logic                           mode;
      logic [asidba_pkg::COUNT_W-1:0] count;
      logic [asidba_pkg::ID_W-1:0]    asid;
   } plan_row_type;

   // typed rows: fail gives one out-of-resource item, a release echoes asid,
   // a reserve grants count ascending identifiers from first
   localparam int N_PLAN = 24;
   localparam plan_row_type PLAN [N_PLAN] = '{
      '{1'b1, 1'b0, 7'd4,   asidba_pkg::MODE_RESERVE, 5'd1,  7'd0},
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd0,  7'd0},
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd17, 7'd0},
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd31, 7'd127},
      '{1'b1, 1'b0, 7'd5,   asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd4,   asidba_pkg::MODE_RELEASE, 5'd0,  7'd4},
      '{1'b0, 1'b0, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd2,  7'd0},
      '{1'b1, 1'b0, 7'd0,   asidba_pkg::MODE_RELEASE, 5'd1,  7'd0},
      '{1'b1, 1'b0, 7'd127, asidba_pkg::MODE_RELEASE, 5'd16, 7'd127},
      '{1'b0, 1'b0, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd1,  7'd0},
      '{1'b1, 1'b0, 7'd22,  asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd38,  asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd54,  asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd70,  asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd86,  asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd102, asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      // only 118..127 left: the claims must be undone
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd16, 7'd0},
      '{1'b1, 1'b0, 7'd118, asidba_pkg::MODE_RESERVE, 5'd10, 7'd0},
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd1,  7'd0},
      '{1'b1, 1'b0, 7'd64,  asidba_pkg::MODE_RELEASE, 5'd0,  7'd64},
      '{1'b1, 1'b0, 7'd85,  asidba_pkg::MODE_RELEASE, 5'd31, 7'd85},
      '{1'b0, 1'b0, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd2,  7'd0},
      '{1'b1, 1'b1, 7'd0,   asidba_pkg::MODE_RESERVE, 5'd3,  7'd0},
      '{1'b1, 1'b0, 7'd42,  asidba_pkg::MODE_RELEASE, 5'd0,  7'd42}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   asidba_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   asidba_pkg::rsp_type rsp_data;

   logic [asidba_pkg::ID_COUNT-1:0] id_used;
   asidba_pkg::rsp_type             predicted[$];
   asidba_pkg::rsp_type             pending_rsp[$];
   asidba_pkg::rsp_type             wanted;
   int                              error_count = 0;
   int                              stall_left = 0;
   logic                            calm = 1'b0;

   asid_bitmap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input int got, input int exp);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, exp);
      error_count++;
   endtask

   // update the identifier map and fill predicted with the items it causes
   function automatic void model_request(input asidba_pkg::req_type r);
      logic [asidba_pkg::ID_W-1:0] claimed[$];
      predicted.delete();
      if (r.mode == asidba_pkg::MODE_RELEASE) begin
         if (int'(r.asid) < asidba_pkg::ID_COUNT) id_used[r.asid] = 1'b0;
         predicted.push_back({r.asid, asidba_pkg::STATUS_OK, 1'b1});
         return;
      end
      if (r.count == 0 || int'(r.count) > asidba_pkg::MAX_REQUEST) begin
         predicted.push_back({7'd0, asidba_pkg::STATUS_NO_ID, 1'b1});
         return;
      end
      for (int id = 0; id < asidba_pkg::ID_COUNT && claimed.size() < int'(r.count); id++) begin
         if (!id_used[id]) begin
            id_used[id] = 1'b1;
            claimed.push_back(asidba_pkg::ID_W'(id));
         end
      end
      if (claimed.size() < int'(r.count)) begin
         foreach (claimed[k]) id_used[claimed[k]] = 1'b0;
         predicted.push_back({7'd0, asidba_pkg::STATUS_NO_ID, 1'b1});
         return;
      end
      foreach (claimed[k])
         predicted.push_back({claimed[k], asidba_pkg::STATUS_OK,
                              1'(k == claimed.size() - 1)});
   endfunction

   // filling: mostly reserves, so the map runs dry and claims get undone;
   // otherwise mostly releases of taken identifiers
   function automatic asidba_pkg::req_type pick_request(input logic filling);
      asidba_pkg::req_type r;
      int                  start;
      int                  slot;
      r.mode  = asidba_pkg::MODE_RESERVE;
      r.count = asidba_pkg::COUNT_W'($urandom_range(0, 31));
      r.asid  = asidba_pkg::ID_W'($urandom());
      if ($urandom_range(0, 99) < 8) begin
         r.mode  = 1'($urandom());
         r.count = ($urandom_range(0, 3) == 0) ? 5'd0 :
                   asidba_pkg::COUNT_W'($urandom_range(17, 31));
         return r;
      end
      if ($urandom_range(0, 99) < (filling ? 20 : 90)) begin
         r.mode = asidba_pkg::MODE_RELEASE;
         if ($urandom_range(0, 9) != 0) begin
            start = $urandom_range(0, asidba_pkg::ID_COUNT - 1);
            for (int i = 0; i < asidba_pkg::ID_COUNT; i++) begin
               slot = (start + i) % asidba_pkg::ID_COUNT;
               if (id_used[slot]) begin
                  r.asid = asidba_pkg::ID_W'(slot);
                  break;
               end
            end
         end
      end else if ($urandom_range(0, 9) < 6) begin
         r.count = asidba_pkg::COUNT_W'($urandom_range(1, 4));
      end else begin
         r.count = asidba_pkg::COUNT_W'($urandom_range(1, asidba_pkg::MAX_REQUEST));
      end
      return r;
   endfunction

   initial begin
      asidba_pkg::req_type item;
      id_used = '0;
      id_used[3:0] = 4'hF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < N_PLAN + RANDOM_ITEMS; n++) begin
         if (n < N_PLAN) item = {PLAN[n].mode, PLAN[n].count, PLAN[n].asid};
         else item = pick_request(((n - N_PLAN) / 40) % 2 == 1);
         calm = (n >= N_PLAN + RANDOM_ITEMS - CALM_ITEMS);
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= item;
         do @(posedge clock); while (req_stall);
         model_request(item);
         if (n < N_PLAN && PLAN[n].typed) begin
            if (PLAN[n].fail) begin
               pending_rsp.push_back({7'd0, asidba_pkg::STATUS_NO_ID, 1'b1});
            end else if (item.mode == asidba_pkg::MODE_RELEASE) begin
               pending_rsp.push_back({item.asid, asidba_pkg::STATUS_OK, 1'b1});
            end else begin
               for (int k = 0; k < int'(item.count); k++)
                  pending_rsp.push_back({7'(PLAN[n].first + k), asidba_pkg::STATUS_OK,
                                         1'(k == int'(item.count) - 1)});
            end
         end else begin
            foreach (predicted[k]) pending_rsp.push_back(predicted[k]);
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected item, granted_id", rsp_data.granted_id, -1);
            end else begin
               wanted = pending_rsp.pop_front();
               if (rsp_data.granted_id !== wanted.granted_id)
                  report_mismatch("granted_id", rsp_data.granted_id, wanted.granted_id);
               if (rsp_data.status !== wanted.status)
                  report_mismatch("status", rsp_data.status, wanted.status);
               if (rsp_data.last !== wanted.last)
                  report_mismatch("last", rsp_data.last, wanted.last);
            end
         end
         // hold the result side stalled in bursts of random length
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

endmodule
